>>> hw/rtl/pip_pkg.sv
// Package for the point-in-polygon crossing-number block.
// Holds the transaction structs, the command struct between controller and
// datapath, and the shared size constants. Depends on nothing.
package pip_pkg;

  localparam int COORD_W      = 16;
  localparam int MAX_VERTICES = 64;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } req_t;

  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] crossing_count;
  } rsp_t;

  typedef struct packed {
    logic             load_pt;
    logic             wr_en;
    logic             rd_en;
    logic             edge_en;
    logic [IDX_W-1:0] rd_addr;
    logic             take_result;
  } pip_cmd_t;

endpackage

>>> hw/rtl/pip_datapath.sv
// Datapath of the point-in-polygon block: vertex table, edge pipeline with
// exact cross-product compare, crossing counter and result register.
// Depends on pip_pkg for sizes, transaction structs and the command struct.
module pip_datapath
  import pip_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  req_t     in_data,
  input  pip_cmd_t cmd,
  output rsp_t     out_data
);

  logic [2*COORD_W-1:0] mem [MAX_VERTICES];
  logic [2*COORD_W-1:0] rd_q;
  logic                 q_edge;

  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic signed [COORD_W-1:0] x1;
  logic signed [COORD_W-1:0] y1;
  logic signed [COORD_W-1:0] x2;
  logic signed [COORD_W-1:0] y2;
  logic signed [COORD_W-1:0] ylo;
  logic signed [COORD_W-1:0] yhi;
  logic signed [COORD_W-1:0] xhi;
  logic signed [DIFF_W-1:0]  dpx;
  logic signed [DIFF_W-1:0]  dpy;
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dy;
  logic signed [PROD_W-1:0]  p1;
  logic signed [PROD_W-1:0]  p2;
  logic                      base_ok;

  logic                      s1_valid;
  logic                      s1_base;
  logic                      s1_vert;
  logic                      s1_dypos;
  logic signed [PROD_W-1:0]  s1_p1;
  logic signed [PROD_W-1:0]  s1_p2;
  logic                      crossed;
  logic [CNT_W-1:0]          count;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[in_data.vertex_index] <= {in_data.coord_x, in_data.coord_y};
    end
    if (cmd.rd_en) begin
      rd_q <= mem[cmd.rd_addr];
    end
  end

  assign x1 = prev_x;
  assign y1 = prev_y;
  assign x2 = rd_q[2*COORD_W-1:COORD_W];
  assign y2 = rd_q[COORD_W-1:0];

  always_comb begin
    ylo     = (y1 < y2) ? y1 : y2;
    yhi     = (y1 < y2) ? y2 : y1;
    xhi     = (x1 < x2) ? x2 : x1;
    base_ok = (py > ylo) && (py <= yhi) && (px <= xhi) && (y1 != y2);
    dpx     = DIFF_W'(px) - DIFF_W'(x1);
    dpy     = DIFF_W'(py) - DIFF_W'(y1);
    dx      = DIFF_W'(x2) - DIFF_W'(x1);
    dy      = DIFF_W'(y2) - DIFF_W'(y1);
    p1      = dpx * dy;
    p2      = dpy * dx;
  end

  assign crossed = s1_base && (s1_vert || (s1_dypos ? (s1_p1 <= s1_p2) : (s1_p1 >= s1_p2)));

  always_ff @(posedge clk) begin
    if (rst) begin
      q_edge   <= 1'b0;
      s1_valid <= 1'b0;
      count    <= '0;
    end else begin
      q_edge   <= cmd.rd_en && cmd.edge_en;
      s1_valid <= q_edge;
      if (cmd.load_pt) begin
        count <= '0;
      end else if (s1_valid && crossed) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      px <= in_data.coord_x;
      py <= in_data.coord_y;
    end
    if (cmd.rd_en) begin
      prev_x <= x2;
      prev_y <= y2;
    end
    s1_base  <= base_ok;
    s1_vert  <= (x1 == x2);
    s1_dypos <= (y2 > y1);
    s1_p1    <= p1;
    s1_p2    <= p2;
    if (cmd.take_result) begin
      out_data.inside_res     <= count[0];
      out_data.crossing_count <= count;
    end
  end

endmodule

>>> hw/rtl/pip_ctrl.sv
// Controller of the point-in-polygon block: handshakes, vertex count
// register, edge walk sequencing and the result valid flag.
// Depends on pip_pkg for sizes, request codes and the command struct.
module pip_ctrl
  import pip_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             req_type,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  output pip_cmd_t         cmd
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_RESULT} state_t;

  state_t           state;
  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] walk_cnt;
  logic             drain_cnt;
  logic             accept;
  logic             out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd             = '0;
    cmd.wr_en       = accept && (req_type == REQ_LOAD);
    cmd.load_pt     = accept && (req_type == REQ_TEST);
    cmd.rd_en       = (state == S_WALK);
    cmd.edge_en     = (walk_cnt != '0);
    cmd.rd_addr     = (walk_cnt == vertex_count) ? '0 : walk_cnt[IDX_W-1:0];
    cmd.take_result = (state == S_RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= '0;
      walk_cnt     <= '0;
      drain_cnt    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= (cfg_data > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : cfg_data;
      end
      out_valid <= cmd.take_result || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          walk_cnt  <= '0;
          drain_cnt <= 1'b0;
          if (accept && (req_type == REQ_TEST)) begin
            state <= (vertex_count < CNT_W'(3)) ? S_RESULT : S_WALK;
          end
        end
        S_WALK: begin
          if (walk_cnt == vertex_count) begin
            state <= S_DRAIN;
          end else begin
            walk_cnt <= walk_cnt + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/point_in_polygon_test.sv
// Top level of the point-in-polygon crossing-number block.
// Instantiates pip_ctrl and pip_datapath; depends on pip_pkg.
//
// A load transaction writes one vertex into the table and leaves the block
// idle. A test transaction walks the edges of the first vertex_count
// vertices, reading one vertex a cycle from the single read port of the
// vertex table, drains the edge pipeline and then registers its result; the
// next transaction can be taken in the same cycle as that result appears.
// With fewer than three vertices the test walks no edge and reports outside
// with a zero count. A test waits in its result state while an earlier
// result is still stalled. The result register holds one finished result
// while the next transaction is taken.
module point_in_polygon_test
  import pip_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_t             out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  pip_cmd_t cmd;

  pip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (in_data.req_type),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd)
  );

  pip_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .in_data (in_data),
    .cmd     (cmd),
    .out_data(out_data)
  );

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.req_type == REQ_LOAD) |=> !in_stall)
    else $error("load transaction left the block busy");

  a_test_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.req_type == REQ_TEST) |=> in_stall)
    else $error("test transaction did not start");

  a_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.inside_res == out_data.crossing_count[0]))
    else $error("inside flag disagrees with crossing count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.crossing_count <= CNT_W'(MAX_VERTICES)))
    else $error("crossing count exceeds vertex table size");

endmodule
